// ----- src/tkis_pkg.sv -----
// package for the top-k insertion selector: payload types, constants, key compare
package tkis_pkg;

    // default capacity of the cell row and default keep count after reset
    localparam int MaxKeepDefault = 16;
    localparam logic [4:0] KeepCountReset = 5'd10;

    // request function codes
    localparam logic FuncOffer = 1'b0;
    localparam logic FuncRead  = 1'b1;

    // one request
    typedef struct packed {
        logic        func;
        logic [11:0] birth_year;
        logic [63:0] name_key;
        logic [15:0] record_ref;
        logic [3:0]  slot;
    } t_req;

    // one result
    typedef struct packed {
        logic        accepted;
        logic [3:0]  place;
        logic        slot_valid;
        logic [11:0] out_year;
        logic [63:0] out_name_key;
        logic [15:0] out_ref;
    } t_rsp;

    // one kept record
    typedef struct packed {
        logic [11:0] year;
        logic [63:0] name;
        logic [15:0] id;
    } t_entry;

    // per-cell control from the row controller
    typedef struct packed {
        logic offer;      // an offer request fires this cycle
        logic active;     // cell index below the effective fill
        logic at_fill;    // cell index equals the effective fill
        logic upto_fill;  // cell index at or below the effective fill
        logic in_range;   // cell index below the effective keep count
    } t_cell_ctl;

    // composite key compare: year first, then name key
    function automatic logic key_less(input t_entry a, input t_entry b);
        key_less = (a.year < b.year) || ((a.year == b.year) && (a.name < b.name));
    endfunction

endpackage

// ----- src/tkis_cell.sv -----
// one cell of the sorted row: holds a record, compares it, loads or shifts
module tkis_cell (
    input  logic               i_clk,
    input  tkis_pkg::t_cell_ctl i_ctl,
    input  tkis_pkg::t_entry    i_new,
    input  logic               i_prev_less,
    input  tkis_pkg::t_entry    i_prev_entry,
    output logic               o_less,
    output logic               o_take_new,
    output tkis_pkg::t_entry    o_entry
);

    tkis_pkg::t_entry r_entry;
    tkis_pkg::t_entry n_entry;
    logic             shift;

    // new key sorts strictly before this cell's key
    assign o_less = i_ctl.active && tkis_pkg::key_less(i_new, r_entry);

    // first cell that is greater, or the free cell at the end of the list
    assign o_take_new = i_ctl.offer && !i_prev_less &&
                        (o_less || (i_ctl.at_fill && i_ctl.in_range));

    // cells above the insertion point move up by one
    assign shift = i_ctl.offer && i_prev_less && i_ctl.upto_fill && i_ctl.in_range;

    // next record
    always_comb begin
        n_entry = r_entry;
        if (o_take_new) begin
            n_entry = i_new;
        end else if (shift) begin
            n_entry = i_prev_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- src/top_k_insertion_selector.sv -----
// top level of the top-k insertion selector: row control, cells, read mux, result register
//
//  channel   signals                     handshake
//  request   start, busy, i_req          taken when start is high and busy low
//  result    o_valid, o_rsp              one-cycle strobe, always taken
//  config    i_cfg_we, i_cfg_wdata       keep_count written when i_cfg_we is high
//
// one request per cycle; the result is registered and appears in the cycle after the request is taken.
// every cell compares the offered key in parallel, so the whole row shifts together when the offer is taken.
// busy stays low; a request may follow its predecessor in the next cycle.
// reset empties the list and sets keep_count to 10; kept record contents are not cleared.
module top_k_insertion_selector #(
    parameter int MAX_KEEP = tkis_pkg::MaxKeepDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tkis_pkg::t_req i_req,
    output logic          o_valid,
    output tkis_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_wdata
);

    localparam int IdxW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int FillW = $clog2(MAX_KEEP + 1);
    localparam int CmpW  = (FillW > 5) ? FillW : 5;
    localparam int PlW   = (IdxW > 4) ? IdxW : 4;

    logic [4:0]       r_keep_count;
    logic [FillW-1:0] r_fill_count;
    logic [FillW-1:0] n_fill_count;
    logic             r_valid;
    tkis_pkg::t_rsp   r_rsp;
    tkis_pkg::t_rsp   n_rsp;

    logic [CmpW-1:0]  keep_ext;
    logic [CmpW-1:0]  fill_ext;
    logic [CmpW-1:0]  k_eff;
    logic [CmpW-1:0]  fill_eff;
    logic [CmpW-1:0]  slot_ext;
    logic [PlW-1:0]   slot_pl;
    logic [IdxW-1:0]  rd_idx;
    logic [IdxW-1:0]  pos;
    logic [PlW-1:0]   pos_ext;
    logic             fire;
    logic             offer;
    logic             accept;

    tkis_pkg::t_entry    new_entry;
    tkis_pkg::t_cell_ctl ctl  [MAX_KEEP];
    tkis_pkg::t_entry    ent  [MAX_KEEP];
    logic [MAX_KEEP-1:0] less;
    logic [MAX_KEEP-1:0] take_new;

    assign busy  = 1'b0;
    assign fire  = start && !busy;
    assign offer = fire && (i_req.func == tkis_pkg::FuncOffer);

    assign new_entry.year = i_req.birth_year;
    assign new_entry.name = i_req.name_key;
    assign new_entry.id   = i_req.record_ref;

    // effective keep count saturated into 1..MAX_KEEP, effective fill at or below it
    always_comb begin
        keep_ext = CmpW'(r_keep_count);
        fill_ext = CmpW'(r_fill_count);
        if (keep_ext == '0) begin
            k_eff = CmpW'(1);
        end else if (keep_ext > CmpW'(MAX_KEEP)) begin
            k_eff = CmpW'(MAX_KEEP);
        end else begin
            k_eff = keep_ext;
        end
        fill_eff = (fill_ext < k_eff) ? fill_ext : k_eff;
    end

    // per-cell control flags
    always_comb begin
        for (int j = 0; j < MAX_KEEP; j++) begin
            ctl[j].offer     = offer;
            ctl[j].active    = CmpW'(j) < fill_eff;
            ctl[j].at_fill   = CmpW'(j) == fill_eff;
            ctl[j].upto_fill = CmpW'(j) <= fill_eff;
            ctl[j].in_range  = CmpW'(j) < k_eff;
        end
    end

    // row of cells, each fed by its left neighbor
    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        if (g == 0) begin : g_first
            tkis_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl[g]),
                .i_new        (new_entry),
                .i_prev_less  (1'b0),
                .i_prev_entry (new_entry),
                .o_less       (less[g]),
                .o_take_new   (take_new[g]),
                .o_entry      (ent[g])
            );
        end else begin : g_rest
            tkis_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl[g]),
                .i_new        (new_entry),
                .i_prev_less  (less[g-1]),
                .i_prev_entry (ent[g-1]),
                .o_less       (less[g]),
                .o_take_new   (take_new[g]),
                .o_entry      (ent[g])
            );
        end
    end

    // insertion place from the one cell that loads the new record
    assign accept = |take_new;
    always_comb begin
        pos = '0;
        for (int j = 0; j < MAX_KEEP; j++) begin
            if (take_new[j]) begin
                pos = pos | IdxW'(j);
            end
        end
    end
    assign pos_ext = PlW'(pos);

    // fill count update
    always_comb begin
        n_fill_count = r_fill_count;
        if (accept) begin
            if (fill_eff < k_eff) begin
                n_fill_count = FillW'(fill_eff + CmpW'(1));
            end else begin
                n_fill_count = FillW'(k_eff);
            end
        end
    end

    // read index and result assembly
    assign slot_ext = CmpW'(i_req.slot);
    assign slot_pl  = PlW'(i_req.slot);
    assign rd_idx   = slot_pl[IdxW-1:0];

    always_comb begin
        n_rsp = '0;
        if (i_req.func == tkis_pkg::FuncRead) begin
            if ((slot_ext < fill_eff) && (slot_ext < CmpW'(MAX_KEEP))) begin
                n_rsp.slot_valid   = 1'b1;
                n_rsp.out_year     = ent[rd_idx].year;
                n_rsp.out_name_key = ent[rd_idx].name;
                n_rsp.out_ref      = ent[rd_idx].id;
            end
        end else begin
            n_rsp.accepted = accept;
            n_rsp.place    = accept ? pos_ext[3:0] : 4'd0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= tkis_pkg::KeepCountReset;
            r_fill_count <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep_count <= i_cfg_wdata;
            end
            r_fill_count <= n_fill_count;
            r_valid      <= fire;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- dv/testbench.sv -----
// testbench for the top-k insertion selector: directed and random requests against a predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxKeep = tkis_pkg::MaxKeepDefault;
    localparam int MaxReported = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    tkis_pkg::t_req i_req;
    logic       o_valid;
    tkis_pkg::t_rsp o_rsp;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;

    // predicted state of the kept list
    tkis_pkg::t_entry kept_rec [MaxKeep];
    int unsigned kept_fill;
    logic [4:0] keep_setting;

    // results waiting for the block
    tkis_pkg::t_rsp expected_rsp_q[$];

    int unsigned gap_max;
    int unsigned mismatch_count;
    int unsigned unexpected_count;
    int unsigned leftover_count;
    int unsigned offers_seen;
    int unsigned offers_placed;
    int unsigned reads_hit;
    int unsigned reads_empty;
    int unsigned keep_writes;

    top_k_insertion_selector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // keep count saturated into 1..MaxKeep
    function automatic int unsigned eff_keep();
        int unsigned k;
        k = 32'(keep_setting);
        if (k < 1) k = 1;
        if (k > MaxKeep) k = MaxKeep;
        return k;
    endfunction

    // number of slots that are compared and readable
    function automatic int unsigned cur_fill();
        int unsigned k;
        k = eff_keep();
        return (kept_fill < k) ? kept_fill : k;
    endfunction

    // year first, then name key
    function automatic bit rec_before(input tkis_pkg::t_entry a, input tkis_pkg::t_entry b);
        return (a.year < b.year) || ((a.year == b.year) && (a.name < b.name));
    endfunction

    // expected result of one request, updating the predicted list
    function automatic tkis_pkg::t_rsp predict_selection(input tkis_pkg::t_req r);
        tkis_pkg::t_rsp rsp;
        tkis_pkg::t_entry fresh;
        int unsigned k;
        int unsigned fill;
        int unsigned pos;
        int unsigned top;
        rsp = '0;
        k = eff_keep();
        fill = cur_fill();
        if (r.func == tkis_pkg::FuncRead) begin
            if (r.slot < fill) begin
                rsp.slot_valid   = 1'b1;
                rsp.out_year     = kept_rec[r.slot].year;
                rsp.out_name_key = kept_rec[r.slot].name;
                rsp.out_ref      = kept_rec[r.slot].id;
                reads_hit++;
            end else begin
                reads_empty++;
            end
            return rsp;
        end
        offers_seen++;
        fresh.year = r.birth_year;
        fresh.name = r.name_key;
        fresh.id   = r.record_ref;
        // full list: only a strictly smaller key gets in
        if (fill >= k && !rec_before(fresh, kept_rec[fill - 1]))
            return rsp;
        // land after every key that is not greater
        pos = fill;
        while (pos > 0 && rec_before(fresh, kept_rec[pos - 1]))
            pos--;
        top = (fill < k) ? fill : k - 1;
        for (int j = top; j > pos; j--)
            kept_rec[j] = kept_rec[j - 1];
        kept_rec[pos] = fresh;
        kept_fill = (fill < k) ? fill + 1 : k;
        rsp.accepted = 1'b1;
        rsp.place    = pos[3:0];
        offers_placed++;
        return rsp;
    endfunction

    function automatic tkis_pkg::t_req offer_req(input logic [11:0] year,
                                                 input logic [63:0] name,
                                                 input logic [15:0] id);
        tkis_pkg::t_req r;
        r = '0;
        r.func       = tkis_pkg::FuncOffer;
        r.birth_year = year;
        r.name_key   = name;
        r.record_ref = id;
        return r;
    endfunction

    function automatic tkis_pkg::t_req read_req(input logic [3:0] slot);
        tkis_pkg::t_req r;
        r = '0;
        r.func = tkis_pkg::FuncRead;
        r.slot = slot;
        return r;
    endfunction

    // send one request after a random gap and queue its expected result
    task automatic send_request(input tkis_pkg::t_req r);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy === 1'b1);
        expected_rsp_q.push_back(predict_selection(r));
    endtask

    // stop requesting and wait for every outstanding result
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // write keep_count while the block is idle
    task automatic write_keep(input logic [4:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        keep_setting = value;
        keep_writes++;
    endtask

    // random request shaped around the current list contents
    task automatic random_request(output tkis_pkg::t_req r);
        int unsigned pick;
        int unsigned fill;
        tkis_pkg::t_entry last;
        logic [63:0] delta;
        r.func       = tkis_pkg::FuncOffer;
        r.birth_year = 12'($urandom);
        r.name_key   = {$urandom, $urandom};
        r.record_ref = 16'($urandom);
        r.slot       = 4'($urandom);
        pick = $urandom_range(0, 99);
        fill = cur_fill();
        if (pick < 35) begin
            r.func = tkis_pkg::FuncRead;
            if ($urandom_range(0, 3) != 0 && fill > 0)
                r.slot = 4'($urandom_range(0, fill - 1));
        end else if (pick < 45) begin
            // fully random offer
        end else if (fill > 0 && pick < 55) begin
            // tie with a kept key
            last = kept_rec[$urandom_range(0, fill - 1)];
            r.birth_year = last.year;
            r.name_key   = last.name;
        end else if (fill >= eff_keep()) begin
            last = kept_rec[fill - 1];
            r.birth_year = last.year;
            r.name_key   = last.name;
            if (pick >= 70) begin
                // just below the last kept key
                delta = 64'($urandom_range(1, 1000));
                if (last.name >= delta) begin
                    r.name_key = last.name - delta;
                end else if (last.name > 0) begin
                    r.name_key = '0;
                end else if (last.year > 0) begin
                    r.birth_year = last.year - 12'd1;
                    r.name_key   = {$urandom, $urandom};
                end
            end
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
                $display("mismatch on %s: expected %0h, got %0h at %0t",
                         field, want, got, $realtime);
        end
    endtask

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        tkis_pkg::t_rsp want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (expected_rsp_q.size() == 0) begin
                unexpected_count++;
                if (unexpected_count <= MaxReported)
                    $display("result with no request pending at %0t", $realtime);
            end else begin
                want = expected_rsp_q.pop_front();
                check_field("accepted", 64'(want.accepted), 64'(o_rsp.accepted));
                check_field("place", 64'(want.place), 64'(o_rsp.place));
                check_field("slot_valid", 64'(want.slot_valid), 64'(o_rsp.slot_valid));
                check_field("out_year", 64'(want.out_year), 64'(o_rsp.out_year));
                check_field("out_name_key", want.out_name_key, o_rsp.out_name_key);
                check_field("out_ref", 64'(want.out_ref), 64'(o_rsp.out_ref));
            end
        end
    end

    // reads of an empty list
    task automatic test_empty_reads();
        send_request(read_req(4'd0));
        send_request(read_req(4'd15));
    endtask

    // extremes of the key, tie-break on name, equal keys land after
    task automatic test_ordering_and_ties();
        send_request(offer_req(12'hFFF, '1, 16'hFFFF));
        send_request(offer_req(12'd0, '0, 16'h0000));
        send_request(offer_req(12'd100, 64'd5, 16'd1));
        send_request(offer_req(12'd100, 64'd5, 16'd2));
        send_request(offer_req(12'd100, 64'd4, 16'd3));
        send_request(offer_req(12'hFFF, '1, 16'd4));
        send_request(read_req(4'd5));
        send_request(read_req(4'd15));
    endtask

    // lowered keep count hides slots, raising it shows them again
    task automatic test_lowered_keep();
        write_keep(5'd3);
        send_request(read_req(4'd2));
        send_request(read_req(4'd3));
        write_keep(5'd10);
        send_request(read_req(4'd5));
        write_keep(5'd3);
        // equal to the last kept key of a full list
        send_request(offer_req(12'd100, 64'd5, 16'd5));
        send_request(offer_req(12'd50, 64'd7, 16'd6));
        write_keep(5'd16);
        send_request(read_req(4'd3));
    endtask

    // keep count of zero and above the capacity
    task automatic test_keep_saturation();
        write_keep(5'd0);
        send_request(offer_req(12'd0, 64'd0, 16'hAAAA));
        send_request(offer_req(12'd7, 64'd1, 16'h5555));
        send_request(read_req(4'd1));
        write_keep(5'd31);
        send_request(offer_req(12'd9, 64'hFFFF_0000_FFFF_0000, 16'h1234));
        write_keep(5'd17);
        send_request(read_req(4'd1));
    endtask

    // random phases at several keep counts, with and without gaps
    task automatic test_random_stream();
        logic [4:0] phase_keep [6] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17};
        tkis_pkg::t_req r;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase < 6)
                write_keep(phase_keep[phase]);
            else
                write_keep(5'($urandom_range(0, 31)));
            gap_max = (phase % 3 == 0) ? 0 : 14;
            for (int n = 0; n < 92; n++) begin
                random_request(r);
                send_request(r);
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        keep_setting = tkis_pkg::KeepCountReset;
        kept_fill    = 0;
        foreach (kept_rec[i]) kept_rec[i] = '0;
        gap_max = 3;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_reads();
        test_ordering_and_ties();
        test_lowered_keep();
        test_keep_saturation();
        test_random_stream();

        drain_results();
        repeat (5) @(posedge i_clk);
        leftover_count = expected_rsp_q.size();

        $display("run covered %0d offers (%0d placed) and %0d reads (%0d hit, %0d empty)",
                 offers_seen, offers_placed, reads_hit + reads_empty, reads_hit, reads_empty);
        $display("%0d keep_count writes; %0d field mismatches, %0d unexpected, %0d missing",
                 keep_writes, mismatch_count, unexpected_count, leftover_count);
        if (mismatch_count == 0 && unexpected_count == 0 && leftover_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout waiting for the block");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tkis_pkg.sv
src/tkis_cell.sv
src/top_k_insertion_selector.sv
dv/testbench.sv
